@@ rtl/i2cmw_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2cmw_pkg
// Types and constants shared by the i2c master write block and its channels.
// ----------------------------------------------------------------------------
package i2cmw_pkg;

   localparam logic [1:0] CMD_TICK   = 2'd0;
   localparam logic [1:0] CMD_BEGIN  = 2'd1;
   localparam logic [1:0] CMD_SUPPLY = 2'd2;

   localparam logic [15:0] HALF_PERIOD_RESET = 16'd100;
   localparam logic [7:0]  SHIFT_RESET       = 8'hFF;
   localparam logic [7:0]  ADDR_MASK         = 8'hFE;
   localparam logic [3:0]  BITS_PER_BYTE     = 4'd8;

   typedef enum logic [14:0] {
      PH_IDLE      = 15'b000000000000001,
      PH_START_SCL = 15'b000000000000010,
      PH_START_HLD = 15'b000000000000100,
      PH_START_LOW = 15'b000000000001000,
      PH_BIT_LOW   = 15'b000000000010000,
      PH_BIT_RISE  = 15'b000000000100000,
      PH_BIT_HIGH  = 15'b000000001000000,
      PH_ACK_LOW   = 15'b000000010000000,
      PH_ACK_RISE  = 15'b000000100000000,
      PH_ACK_HIGH  = 15'b000001000000000,
      PH_WANT      = 15'b000010000000000,
      PH_STOP_LOW  = 15'b000100000000000,
      PH_STOP_RISE = 15'b001000000000000,
      PH_STOP_HLD  = 15'b010000000000000,
      PH_STOP_END  = 15'b100000000000000
   } phase_type;

   typedef struct packed {
      logic [1:0] command;
      logic [6:0] target_address;
      logic [6:0] byte_count;
      logic [7:0] tx_byte;
      logic       scl_level;
      logic       sda_level;
   } req_payload_type;

   typedef struct packed {
      logic scl_pull_low;
      logic sda_pull_low;
      logic busy_res;
      logic byte_wanted;
      logic ack_valid;
      logic ack_level;
      logic done_res;
   } rsp_payload_type;

endpackage

@@ rtl/i2cmw_chan_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2cmw_chan_if
// Valid/ready channel carrying one payload per transaction.
// ----------------------------------------------------------------------------
interface i2cmw_chan_if #(
   parameter type payload_type = logic
);
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

@@ rtl/i2c_master_write_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2c_master_write_top
// Open-drain i2c master for write transactions, stepped one request per cycle.
// ----------------------------------------------------------------------------
// Every accepted request (tick with line samples, begin, or supply byte)
// produces exactly one response in the next cycle, holding the line drives and
// status after that step. A new request is taken every cycle while the
// response register is empty or being drained, so the sustained rate is one
// transaction per cycle; it is set by the single-step update of the phase
// state machine and its counters. csr_wr_en writes the half period in ticks
// (zero acts as one); write it only when no response is pending.
module i2c_master_write_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_wr_en,
   input  logic [15:0] csr_wr_data,
   i2cmw_chan_if.sink   req_chan,
   i2cmw_chan_if.source rsp_chan
);
   import i2cmw_pkg::*;

   logic [15:0]     half_period_ff;
   phase_type       phase_ff, phase_in;
   logic [3:0]      bit_index_ff, bit_index_in;
   logic [7:0]      shift_byte_ff, shift_byte_in;
   logic [6:0]      bytes_left_ff, bytes_left_in;
   logic [15:0]     wait_count_ff, wait_count_in;
   logic            scl_drive_ff, scl_drive_in;
   logic            sda_drive_ff, sda_drive_in;
   logic            ack_seen_ff, ack_seen_in;
   logic            rsp_valid_ff;
   rsp_payload_type rsp_ff, rsp_in;

   req_payload_type req;
   logic            req_fire;
   logic [15:0]     limit;
   logic [15:0]     wc_inc;
   logic            half_done;
   logic [3:0]      bit_inc;
   logic [7:0]      shift_next;
   logic            ack_v;
   logic            done;

   assign req            = req_chan.payload;
   assign req_chan.ready = !rsp_valid_ff || rsp_chan.ready;
   assign req_fire       = req_chan.valid && req_chan.ready;
   assign rsp_chan.valid   = rsp_valid_ff;
   assign rsp_chan.payload = rsp_ff;

   assign limit      = (half_period_ff == 16'd0) ? 16'd1 : half_period_ff;
   assign wc_inc     = wait_count_ff + 16'd1;
   assign half_done  = wc_inc >= limit;
   assign bit_inc    = bit_index_ff + 4'd1;
   assign shift_next = {shift_byte_ff[6:0], 1'b1};

   always_comb begin
      phase_in      = phase_ff;
      bit_index_in  = bit_index_ff;
      shift_byte_in = shift_byte_ff;
      bytes_left_in = bytes_left_ff;
      wait_count_in = wait_count_ff;
      scl_drive_in  = scl_drive_ff;
      sda_drive_in  = sda_drive_ff;
      ack_seen_in   = ack_seen_ff;
      ack_v         = 1'b0;
      done          = 1'b0;

      if (req_fire) begin
         case (req.command)
            CMD_BEGIN: begin
               if (phase_ff == PH_IDLE) begin
                  shift_byte_in = {req.target_address, 1'b0} & ADDR_MASK;
                  bytes_left_in = req.byte_count;
                  bit_index_in  = 4'd0;
                  wait_count_in = 16'd0;
                  scl_drive_in  = 1'b0;
                  sda_drive_in  = 1'b0;
                  phase_in      = PH_START_SCL;
               end
            end
            CMD_SUPPLY: begin
               if (phase_ff == PH_WANT) begin
                  shift_byte_in = req.tx_byte;
                  bytes_left_in = bytes_left_ff - 7'd1;
                  bit_index_in  = 4'd0;
                  wait_count_in = 16'd0;
                  sda_drive_in  = !req.tx_byte[7];
                  phase_in      = PH_BIT_LOW;
               end
            end
            CMD_TICK: begin
               case (phase_ff)
                  PH_START_SCL: begin
                     if (req.scl_level) begin
                        sda_drive_in  = 1'b1;
                        wait_count_in = 16'd0;
                        phase_in      = PH_START_HLD;
                     end
                  end
                  PH_START_HLD: begin
                     wait_count_in = half_done ? 16'd0 : wc_inc;
                     if (half_done) begin
                        scl_drive_in = 1'b1;
                        phase_in     = PH_START_LOW;
                     end
                  end
                  PH_START_LOW: begin
                     wait_count_in = half_done ? 16'd0 : wc_inc;
                     if (half_done) begin
                        bit_index_in = 4'd0;
                        sda_drive_in = !shift_byte_ff[7];
                        phase_in     = PH_BIT_LOW;
                     end
                  end
                  PH_BIT_LOW: begin
                     wait_count_in = half_done ? 16'd0 : wc_inc;
                     if (half_done) begin
                        scl_drive_in = 1'b0;
                        phase_in     = PH_BIT_RISE;
                     end
                  end
                  PH_BIT_RISE: begin
                     if (req.scl_level) begin
                        wait_count_in = 16'd0;
                        phase_in      = PH_BIT_HIGH;
                     end
                  end
                  PH_BIT_HIGH: begin
                     wait_count_in = half_done ? 16'd0 : wc_inc;
                     if (half_done) begin
                        scl_drive_in  = 1'b1;
                        bit_index_in  = bit_inc;
                        shift_byte_in = shift_next;
                        if (bit_inc >= BITS_PER_BYTE) begin
                           sda_drive_in = 1'b0;
                           phase_in     = PH_ACK_LOW;
                        end else begin
                           sda_drive_in = !shift_next[7];
                           phase_in     = PH_BIT_LOW;
                        end
                     end
                  end
                  PH_ACK_LOW: begin
                     wait_count_in = half_done ? 16'd0 : wc_inc;
                     if (half_done) begin
                        scl_drive_in = 1'b0;
                        phase_in     = PH_ACK_RISE;
                     end
                  end
                  PH_ACK_RISE: begin
                     // acknowledge is sampled on the first tick scl reads high
                     if (req.scl_level) begin
                        ack_seen_in   = req.sda_level;
                        ack_v         = 1'b1;
                        wait_count_in = 16'd0;
                        phase_in      = PH_ACK_HIGH;
                     end
                  end
                  PH_ACK_HIGH: begin
                     wait_count_in = half_done ? 16'd0 : wc_inc;
                     if (half_done) begin
                        scl_drive_in = 1'b1;
                        if (bytes_left_ff != 7'd0) begin
                           sda_drive_in = 1'b0;
                           phase_in     = PH_WANT;
                        end else begin
                           sda_drive_in = 1'b1;
                           phase_in     = PH_STOP_LOW;
                        end
                     end
                  end
                  PH_STOP_LOW: begin
                     wait_count_in = half_done ? 16'd0 : wc_inc;
                     if (half_done) begin
                        scl_drive_in = 1'b0;
                        phase_in     = PH_STOP_RISE;
                     end
                  end
                  PH_STOP_RISE: begin
                     if (req.scl_level) begin
                        wait_count_in = 16'd0;
                        phase_in      = PH_STOP_HLD;
                     end
                  end
                  PH_STOP_HLD: begin
                     wait_count_in = half_done ? 16'd0 : wc_inc;
                     if (half_done) begin
                        sda_drive_in = 1'b0;
                        phase_in     = PH_STOP_END;
                     end
                  end
                  PH_STOP_END: begin
                     wait_count_in = half_done ? 16'd0 : wc_inc;
                     if (half_done) begin
                        done     = 1'b1;
                        phase_in = PH_IDLE;
                     end
                  end
                  default: begin
                  end
               endcase
            end
            default: begin
            end
         endcase
      end

      rsp_in.scl_pull_low = scl_drive_in;
      rsp_in.sda_pull_low = sda_drive_in;
      rsp_in.busy_res     = phase_in != PH_IDLE;
      rsp_in.byte_wanted  = phase_in == PH_WANT;
      rsp_in.ack_valid    = ack_v;
      rsp_in.ack_level    = ack_seen_in;
      rsp_in.done_res     = done;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         half_period_ff <= HALF_PERIOD_RESET;
         phase_ff       <= PH_IDLE;
         bit_index_ff   <= 4'd0;
         shift_byte_ff  <= SHIFT_RESET;
         bytes_left_ff  <= 7'd0;
         wait_count_ff  <= 16'd0;
         scl_drive_ff   <= 1'b0;
         sda_drive_ff   <= 1'b0;
         ack_seen_ff    <= 1'b1;
         rsp_valid_ff   <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            half_period_ff <= csr_wr_data;
         end
         phase_ff      <= phase_in;
         bit_index_ff  <= bit_index_in;
         shift_byte_ff <= shift_byte_in;
         bytes_left_ff <= bytes_left_in;
         wait_count_ff <= wait_count_in;
         scl_drive_ff  <= scl_drive_in;
         sda_drive_ff  <= sda_drive_in;
         ack_seen_ff   <= ack_seen_in;
         if (req_fire) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_chan.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         rsp_ff <= rsp_in;
      end
   end

   // a completed stop leaves the block idle
   a_done_not_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.done_res |-> !rsp_ff.busy_res)
      else $error("done reported while still busy");

   a_wanted_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.byte_wanted |-> rsp_ff.busy_res)
      else $error("byte wanted outside a transaction");

   // an acknowledge sample always moves the state machine into the ack high half
   a_ack_phase: assert property (@(posedge clock) disable iff (reset)
      req_fire && ack_v |=> phase_ff == PH_ACK_HIGH && ack_seen_ff == rsp_ff.ack_level)
      else $error("ack sampled without entering ack high phase");

   // state only moves on an accepted transaction
   a_hold_idle: assert property (@(posedge clock) disable iff (reset)
      !req_fire |=> $stable(phase_ff) && $stable(wait_count_ff))
      else $error("state changed without a request");

endmodule
